/* rtl/core/tsq_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants for the touch sample qualifier
// Opcodes, register indexes, window size and the structs passed between
// the top level and the step logic.
// ----------------------------------------------------------------------------
package tsq_pkg;

    localparam int SAMPLES = 8;                       // bounds window length
    localparam int CNT_W   = $clog2(SAMPLES + 1);     // window counter width
    localparam int COORD_W = 16;
    localparam int TOL_W   = 16;
    localparam int OP_W    = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [TOL_W-1:0] PAIR_TOL_RESET   = TOL_W'(10);
    localparam logic [TOL_W-1:0] SPREAD_TOL_RESET = TOL_W'(4);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PAIR_TOL   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SPREAD_TOL = 1'd1;

    // opcodes
    localparam logic [OP_W-1:0] OP_PAIR    = 3'd0;
    localparam logic [OP_W-1:0] OP_SINGLE  = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd2;
    localparam logic [OP_W-1:0] OP_LPOLL   = 3'd3;
    localparam logic [OP_W-1:0] OP_TPOLL   = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]           opcode;
        logic signed [COORD_W-1:0] x_first;
        logic signed [COORD_W-1:0] y_first;
        logic signed [COORD_W-1:0] x_second;
        logic signed [COORD_W-1:0] y_second;
    } t_sample;

    // control state, cleared by reset
    typedef struct packed {
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      contact;
        logic                      touched;
        logic [CNT_W-1:0]          count;
    } t_state;

    // running bounding box, loaded by the first sample of a window, then widened
    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_y;
    } t_bounds;

    typedef struct packed {
        logic                      event_flag;
        logic signed [COORD_W-1:0] pos_x;
        logic signed [COORD_W-1:0] pos_y;
        logic                      contact;
    } t_result;

endpackage
`default_nettype wire

/* rtl/core/tsq_sample_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_sample_if: sample channel
// valid/ready handshake carrying one touch sample or command.
// ----------------------------------------------------------------------------
interface tsq_sample_if;
    logic                                     valid;
    logic                                     ready;
    logic [tsq_pkg::OP_W-1:0]                 opcode;
    logic signed [tsq_pkg::COORD_W-1:0]       x_first;
    logic signed [tsq_pkg::COORD_W-1:0]       y_first;
    logic signed [tsq_pkg::COORD_W-1:0]       x_second;
    logic signed [tsq_pkg::COORD_W-1:0]       y_second;

    modport source (output valid, opcode, x_first, y_first, x_second, y_second,
                    input ready);
    modport sink   (input valid, opcode, x_first, y_first, x_second, y_second,
                    output ready);
endinterface
`default_nettype wire

/* rtl/core/tsq_result_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_result_if: result channel
// valid/ready handshake carrying one result per sample transfer.
// ----------------------------------------------------------------------------
interface tsq_result_if;
    logic                               valid;
    logic                               ready;
    logic                               event_flag;
    logic signed [tsq_pkg::COORD_W-1:0] pos_x;
    logic signed [tsq_pkg::COORD_W-1:0] pos_y;
    logic                               contact;

    modport source (output valid, event_flag, pos_x, pos_y, contact, input ready);
    modport sink   (input valid, event_flag, pos_x, pos_y, contact, output ready);
endinterface
`default_nettype wire

/* rtl/core/tsq_cfg_if.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_cfg_if: configuration write channel
// valid/ready handshake carrying a register index and write data.
// ----------------------------------------------------------------------------
interface tsq_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [tsq_pkg::CFG_IDX_W-1:0]    index;
    logic [tsq_pkg::TOL_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/core/tsq_step.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_step: one-item update logic
// Qualifies a sample, updates position, contact and bounds, answers polls.
// ----------------------------------------------------------------------------
module tsq_step (
    input  wire tsq_pkg::t_sample         i_sample,
    input  wire tsq_pkg::t_state          i_state,
    input  wire tsq_pkg::t_bounds         i_bounds,
    input  wire [tsq_pkg::TOL_W-1:0]      i_pair_tol,
    input  wire [tsq_pkg::TOL_W-1:0]      i_spread_tol,
    output tsq_pkg::t_state               o_state,
    output tsq_pkg::t_bounds              o_bounds,
    output logic                          o_event
);

    localparam int W1 = tsq_pkg::COORD_W + 1;

    logic signed [W1-1:0] dx, dy, adx, ady, sx, sy, sx_adj, sy_adj;
    logic signed [W1-1:0] spr_x, spr_y;
    logic                 pair_ok, spread_ok, full, first;
    logic                 take;
    logic signed [tsq_pkg::COORD_W-1:0] px, py;

    always_comb begin
        // pair test: both |second - first| below tolerance
        dx  = $signed({i_sample.x_second[tsq_pkg::COORD_W-1], i_sample.x_second})
            - $signed({i_sample.x_first[tsq_pkg::COORD_W-1], i_sample.x_first});
        dy  = $signed({i_sample.y_second[tsq_pkg::COORD_W-1], i_sample.y_second})
            - $signed({i_sample.y_first[tsq_pkg::COORD_W-1], i_sample.y_first});
        adx = dx[W1-1] ? -dx : dx;
        ady = dy[W1-1] ? -dy : dy;
        pair_ok = ($unsigned(adx) < {1'b0, i_pair_tol})
               && ($unsigned(ady) < {1'b0, i_pair_tol});

        // average, truncated toward zero
        sx = $signed({i_sample.x_first[tsq_pkg::COORD_W-1], i_sample.x_first})
           + $signed({i_sample.x_second[tsq_pkg::COORD_W-1], i_sample.x_second});
        sy = $signed({i_sample.y_first[tsq_pkg::COORD_W-1], i_sample.y_first})
           + $signed({i_sample.y_second[tsq_pkg::COORD_W-1], i_sample.y_second});
        sx_adj = sx + $signed({{(W1-1){1'b0}}, sx[W1-1]});
        sy_adj = sy + $signed({{(W1-1){1'b0}}, sy[W1-1]});

        full  = (i_state.count >= tsq_pkg::CNT_W'(tsq_pkg::SAMPLES));
        first = (i_state.count == '0);

        spr_x = $signed({i_bounds.max_x[tsq_pkg::COORD_W-1], i_bounds.max_x})
              - $signed({i_bounds.min_x[tsq_pkg::COORD_W-1], i_bounds.min_x});
        spr_y = $signed({i_bounds.max_y[tsq_pkg::COORD_W-1], i_bounds.max_y})
              - $signed({i_bounds.min_y[tsq_pkg::COORD_W-1], i_bounds.min_y});
        spread_ok = ($unsigned(spr_x) < {1'b0, i_spread_tol})
                 && ($unsigned(spr_y) < {1'b0, i_spread_tol});

        take = 1'b0;
        px   = i_sample.x_first;
        py   = i_sample.y_first;
        o_state  = i_state;
        o_bounds = i_bounds;
        o_event  = 1'b0;

        case (i_sample.opcode)
            tsq_pkg::OP_PAIR: begin
                take = pair_ok;
                px   = sx_adj[W1-1:1];
                py   = sy_adj[W1-1:1];
            end
            tsq_pkg::OP_SINGLE: begin
                take = 1'b1;
            end
            tsq_pkg::OP_RELEASE: begin
                o_state.contact = 1'b0;
                o_state.touched = 1'b0;
            end
            tsq_pkg::OP_LPOLL: begin
                if (full) begin
                    o_state.count = '0;
                    if (spread_ok && i_state.contact && !i_state.touched) begin
                        o_state.touched = 1'b1;
                        o_event = 1'b1;
                    end
                end
            end
            tsq_pkg::OP_TPOLL: begin
                if (i_state.contact && !i_state.touched) begin
                    o_state.touched = 1'b1;
                    o_event = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (take) begin
            o_state.pos_x   = px;
            o_state.pos_y   = py;
            o_state.contact = 1'b1;
            if (!full) begin
                o_state.count = i_state.count + tsq_pkg::CNT_W'(1);
                if (first) begin
                    o_bounds.min_x = px;
                    o_bounds.max_x = px;
                    o_bounds.min_y = py;
                    o_bounds.max_y = py;
                end else begin
                    if (px < i_bounds.min_x) o_bounds.min_x = px;
                    if (px > i_bounds.max_x) o_bounds.max_x = px;
                    if (py < i_bounds.min_y) o_bounds.min_y = py;
                    if (py > i_bounds.max_y) o_bounds.max_y = py;
                end
            end
        end
    end

endmodule
`default_nettype wire

/* rtl/core/touch_sample_qualifier.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// touch_sample_qualifier: touch-panel sample qualifier
// Filters pair/single samples, tracks contact and a window bounding box,
// and answers touch and long-press polls.
// ----------------------------------------------------------------------------
// Each sample transfer produces exactly one result transfer. A transfer is
// captured in an input register, processed combinationally by the step logic
// (compares, a 17-bit add per axis, min/max update) and lands in the result
// register once that register is free or draining. While the result side
// does not stall, the block sustains one item per clock. Throughput is set
// by the state feedback loop through the step logic: each item updates
// position, contact, window counter and bounds before the next one is
// processed. The result register decouples the two sides; a stalled result
// holds the input stage, which in turn drops i_sample.ready. Configuration
// writes are always accepted (i_cfg.ready is tied high) and must only be
// issued while idle.
// Bounds registers are not reset; the first sample of each window loads them.
// ----------------------------------------------------------------------------
module touch_sample_qualifier (
    input  wire         i_clk,
    input  wire         i_rst_n,
    tsq_sample_if.sink  i_sample,
    tsq_cfg_if.sink     i_cfg,
    tsq_result_if.source o_result
);

    // configuration
    logic [tsq_pkg::TOL_W-1:0] r_pair_tol, r_spread_tol;

    // input stage
    logic             r_s1_valid;
    tsq_pkg::t_sample r_s1;
    logic             s1_go;

    // block state
    tsq_pkg::t_state  r_state, n_state;
    tsq_pkg::t_bounds r_bounds, n_bounds;
    logic             n_event;

    // result stage
    logic             r_out_valid;
    tsq_pkg::t_result r_out;

    // input stage moves on when the result register is free or draining
    assign s1_go          = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_sample.ready = !r_s1_valid || s1_go;
    assign i_cfg.ready    = 1'b1;

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair_tol   <= tsq_pkg::PAIR_TOL_RESET;
            r_spread_tol <= tsq_pkg::SPREAD_TOL_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                tsq_pkg::REG_PAIR_TOL:   r_pair_tol   <= i_cfg.data;
                tsq_pkg::REG_SPREAD_TOL: r_spread_tol <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_sample.ready) begin
            r_s1_valid <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_sample.valid && i_sample.ready) begin
            r_s1.opcode   <= i_sample.opcode;
            r_s1.x_first  <= i_sample.x_first;
            r_s1.y_first  <= i_sample.y_first;
            r_s1.x_second <= i_sample.x_second;
            r_s1.y_second <= i_sample.y_second;
        end
    end

    tsq_step u_step (
        .i_sample     (r_s1),
        .i_state      (r_state),
        .i_bounds     (r_bounds),
        .i_pair_tol   (r_pair_tol),
        .i_spread_tol (r_spread_tol),
        .o_state      (n_state),
        .o_bounds     (n_bounds),
        .o_event      (n_event)
    );

    // state commits only when the item moves into the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (s1_go) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_bounds <= n_bounds;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_out.event_flag <= n_event;
            r_out.pos_x      <= n_state.pos_x;
            r_out.pos_y      <= n_state.pos_y;
            r_out.contact    <= n_state.contact;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.event_flag = r_out.event_flag;
    assign o_result.pos_x      = r_out.pos_x;
    assign o_result.pos_y      = r_out.pos_y;
    assign o_result.contact    = r_out.contact;

endmodule
`default_nettype wire
